// ----- sv/arr_pkg.sv -----
// Shared types, constants and the hash step of the address range registry.
// Used by arr_store and address_range_registry; depends on nothing else.
`timescale 1ns / 1ps
package arr_pkg;

   localparam int TableEntries = 64;
   localparam int IdxWidth     = $clog2(TableEntries);
   localparam int CountWidth   = $clog2(TableEntries + 1);

   localparam logic [63:0] HashSeed = 64'd1469598103934665603;

   typedef enum logic [1:0] {
      CMD_TRACK  = 2'd0,
      CMD_FORGET = 2'd1,
      CMD_QUERY  = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] start_addr;
      logic [63:0] end_addr;
      logic [63:0] ident;
   } entry_type;

   typedef struct packed {
      logic                rd_en;
      logic [IdxWidth-1:0] rd_addr;
      logic                wr_en;
      logic                clr_en;
      logic [IdxWidth-1:0] wr_addr;
      entry_type           wr_data;
   } store_req_type;

   typedef struct packed {
      entry_type           rd_data;
      logic                rd_vld;
      logic [IdxWidth-1:0] free_idx;
   } store_rsp_type;

   // Multiplication by the prime 2^40 + 2^8 + 0xb3, written as shifted adds.
   function automatic logic [63:0] hash_step(logic [63:0] x);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// ----- sv/address_range_registry.sv -----
// An invalid, rejected or unused command goes straight to the response state; track and forget
// make one pass over the table memory,
// one read per cycle, then up to two slot writes.
// A query may scan the table once for each covering range, plus a pass that finds a gap.
// One word is worked on at a time; the output register takes the result while the next word
// is accepted. Synchronous reset empties the table (valid bits) and clears the identity counter.
`timescale 1ns / 1ps
module address_range_registry (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_base_address,
   input  logic [63:0] req_range_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_identity_hash,
   output logic [1:0]  rsp_status
);

   localparam int IW = arr_pkg::IdxWidth;
   localparam int CW = arr_pkg::CountWidth;
   localparam logic [IW-1:0] LastIdx = IW'(arr_pkg::TableEntries - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CUT   = 5'b00010,
      S_FILL  = 5'b00100,
      S_QUERY = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [63:0]            lo_ff, lo_in;
   logic [63:0]            hi_ff, hi_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   rd_more_ff, rd_more_in;
   logic                   ev_on_ff, ev_on_in;
   logic [IW-1:0]          ev_idx_ff, ev_idx_in;
   logic                   pend_ff, pend_in;
   arr_pkg::entry_type     pend_ent_ff, pend_ent_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [63:0]            idctr_ff, idctr_in;
   logic [63:0]            hash_ff, hash_in;
   logic [CW-1:0]          miss_ff, miss_in;
   logic [63:0]            res_hash_ff, res_hash_in;
   arr_pkg::status_type    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [63:0]            rsp_hash_ff, rsp_hash_in;
   arr_pkg::status_type    rsp_status_ff, rsp_status_in;

   arr_pkg::store_req_type sreq;
   arr_pkg::store_rsp_type srsp;

   logic [64:0]            sum;
   logic                   bad_range;
   logic                   table_full;
   logic [63:0]            ent_s, ent_e;
   logic                   overlap, lower, upper, hit;
   logic [63:0]            mixed;

   arr_store u_store (
      .clock (clock),
      .reset (reset),
      .sreq  (sreq),
      .srsp  (srsp)
   );

   assign sum        = {1'b0, req_base_address} + {1'b0, req_range_length};
   assign bad_range  = (req_base_address == 64'd0) || (req_range_length == 64'd0) || sum[64];
   assign table_full = ((CW + 1)'(count_ff) + (CW + 1)'(2)) > (CW + 1)'(arr_pkg::TableEntries);
   assign ent_s      = srsp.rd_data.start_addr;
   assign ent_e      = srsp.rd_data.end_addr;
   assign overlap    = srsp.rd_vld && (ent_s < hi_ff) && (ent_e > lo_ff);
   assign lower      = ent_s < lo_ff;
   assign upper      = ent_e > hi_ff;
   assign hit        = srsp.rd_vld && (ent_s <= lo_ff) && (ent_e > lo_ff);
   assign mixed      = arr_pkg::hash_step(hash_ff ^ srsp.rd_data.ident);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rd_idx_in     = rd_idx_ff;
      rd_more_in    = rd_more_ff;
      ev_on_in      = 1'b0;
      ev_idx_in     = ev_idx_ff;
      pend_in       = pend_ff;
      pend_ent_in   = pend_ent_ff;
      count_in      = count_ff;
      idctr_in      = idctr_ff;
      hash_in       = hash_ff;
      miss_in       = miss_ff;
      res_hash_in   = res_hash_ff;
      res_status_in = res_status_ff;
      rsp_hash_in   = rsp_hash_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      sreq          = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               lo_in         = req_base_address;
               hi_in         = sum[63:0];
               res_hash_in   = 64'd0;
               res_status_in = arr_pkg::ST_DONE;
               rd_idx_in     = '0;
               rd_more_in    = 1'b1;
               pend_in       = 1'b0;
               hash_in       = arr_pkg::HashSeed;
               miss_in       = '0;
               if (req_command != arr_pkg::CMD_TRACK && req_command != arr_pkg::CMD_FORGET
                   && req_command != arr_pkg::CMD_QUERY) begin
                  state_in = S_RESP;
               end else if (bad_range) begin
                  res_status_in = arr_pkg::ST_INVALID;
                  state_in      = S_RESP;
               end else if (req_command == arr_pkg::CMD_QUERY) begin
                  state_in = S_QUERY;
               end else if (table_full) begin
                  res_status_in = arr_pkg::ST_FULL;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_CUT;
               end
            end
         end
         S_CUT: begin
            if (rd_more_ff) begin
               sreq.rd_en   = 1'b1;
               sreq.rd_addr = rd_idx_ff;
               rd_idx_in    = rd_idx_ff + IW'(1);
               if (rd_idx_ff == LastIdx) begin
                  rd_more_in = 1'b0;
               end
            end
            ev_on_in  = rd_more_ff;
            ev_idx_in = rd_idx_ff;
            if (ev_on_ff && overlap) begin
               sreq.wr_addr = ev_idx_ff;
               sreq.wr_data = srsp.rd_data;
               if (lower) begin
                  sreq.wr_en              = 1'b1;
                  sreq.wr_data.end_addr   = lo_ff;
                  if (upper) begin
                     pend_in                = 1'b1;
                     pend_ent_in            = srsp.rd_data;
                     pend_ent_in.start_addr = hi_ff;
                  end
               end else if (upper) begin
                  sreq.wr_en              = 1'b1;
                  sreq.wr_data.start_addr = hi_ff;
               end else begin
                  sreq.clr_en = 1'b1;
                  count_in    = count_ff - CW'(1);
               end
            end
            if (ev_on_ff && ev_idx_ff == LastIdx) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            sreq.wr_addr = srsp.free_idx;
            if (pend_ff) begin
               sreq.wr_en   = 1'b1;
               sreq.wr_data = pend_ent_ff;
               pend_in      = 1'b0;
               count_in     = count_ff + CW'(1);
            end else if (cmd_ff == arr_pkg::CMD_TRACK) begin
               sreq.wr_en              = 1'b1;
               sreq.wr_data.start_addr = lo_ff;
               sreq.wr_data.end_addr   = hi_ff;
               sreq.wr_data.ident      = idctr_ff + 64'd1;
               idctr_in                = idctr_ff + 64'd1;
               count_in                = count_ff + CW'(1);
               state_in                = S_RESP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_QUERY: begin
            sreq.rd_en   = 1'b1;
            sreq.rd_addr = rd_idx_ff;
            rd_idx_in    = (rd_idx_ff == LastIdx) ? '0 : rd_idx_ff + IW'(1);
            ev_on_in     = 1'b1;
            if (ev_on_ff) begin
               if (hit) begin
                  hash_in = mixed;
                  lo_in   = ent_e;
                  miss_in = '0;
                  if (ent_e >= hi_ff) begin
                     res_hash_in = (mixed == 64'd0) ? 64'd1 : mixed;
                     state_in    = S_RESP;
                  end
               end else begin
                  miss_in = miss_ff + CW'(1);
                  if (miss_ff == CW'(arr_pkg::TableEntries - 1)) begin
                     res_hash_in = 64'd0;
                     state_in    = S_RESP;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_hash_in   = res_hash_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_more_ff   <= 1'b0;
         ev_on_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         idctr_ff     <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_more_ff   <= rd_more_in;
         ev_on_ff     <= ev_on_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         idctr_ff     <= idctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rd_idx_ff     <= rd_idx_in;
      ev_idx_ff     <= ev_idx_in;
      pend_ent_ff   <= pend_ent_in;
      hash_ff       <= hash_in;
      miss_ff       <= miss_in;
      res_hash_ff   <= res_hash_in;
      res_status_ff <= res_status_in;
      rsp_hash_ff   <= rsp_hash_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_identity_hash = rsp_hash_ff;
   assign rsp_status        = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(arr_pkg::TableEntries))
      else $error("entry count exceeds table size");

   a_reject_no_hash : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != arr_pkg::ST_DONE |-> rsp_hash_ff == 64'd0)
      else $error("rejected word carries a hash");

   a_ident_only_fill : assert property (@(posedge clock) disable iff (reset)
      state_ff != S_FILL |=> $stable(idctr_ff))
      else $error("identity counter moved outside slot fill");

   a_miss_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_QUERY |-> miss_ff < CW'(arr_pkg::TableEntries))
      else $error("query miss counter overran the table");

endmodule

// ----- sv/arr_store.sv -----
// Range table storage: one synchronous memory of entries, their valid bits
// and the first-free-slot encoder. Depends on arr_pkg.
`timescale 1ns / 1ps
module arr_store (
   input  logic                  clock,
   input  logic                  reset,
   input  arr_pkg::store_req_type sreq,
   output arr_pkg::store_rsp_type srsp
);

   arr_pkg::entry_type                 mem [arr_pkg::TableEntries];
   arr_pkg::entry_type                 rd_data_ff;
   logic [arr_pkg::IdxWidth-1:0]       rd_addr_ff;
   logic [arr_pkg::TableEntries-1:0]   valid_ff;
   logic [arr_pkg::TableEntries-1:0]   valid_in;
   logic [arr_pkg::IdxWidth-1:0]       free_idx;

   always_ff @(posedge clock) begin
      if (sreq.wr_en) begin
         mem[sreq.wr_addr] <= sreq.wr_data;
      end
      if (sreq.rd_en) begin
         rd_data_ff <= mem[sreq.rd_addr];
         rd_addr_ff <= sreq.rd_addr;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (sreq.wr_en) begin
         valid_in[sreq.wr_addr] = 1'b1;
      end
      if (sreq.clr_en) begin
         valid_in[sreq.wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      free_idx = '0;
      for (int i = arr_pkg::TableEntries - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = arr_pkg::IdxWidth'(i);
         end
      end
   end

   assign srsp.rd_data  = rd_data_ff;
   assign srsp.rd_vld   = valid_ff[rd_addr_ff];
   assign srsp.free_idx = free_idx;

endmodule

// ----- dv/tb_address_range_registry.sv -----
// Self-checking testbench for the address range registry: random and directed range words.
// Holds its own table predictor and compares every response word; depends on arr_pkg and the RTL.
`timescale 1ns / 1ps
module tb_address_range_registry;

   localparam logic [63:0] HashPrime = 64'd1099511628211;
   localparam logic [1:0]  CmdUnused = 2'd3;

   typedef struct {
      logic [1:0]  command;
      logic [63:0] base;
      logic [63:0] length;
   } range_word_type;

   typedef struct {
      logic [63:0] ident_hash;
      logic [1:0]  status;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [63:0] req_base_address;
   logic [63:0] req_range_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_identity_hash;
   logic [1:0]  rsp_status;

   range_word_type pending_words[$];
   answer_type     expected_answers[$];

   logic [63:0] model_start[arr_pkg::TableEntries];
   logic [63:0] model_end[arr_pkg::TableEntries];
   logic [63:0] model_ident[arr_pkg::TableEntries];
   bit          model_valid[arr_pkg::TableEntries];
   int          model_count;
   logic [63:0] model_counter;

   int  mismatches;
   int  words_sent;
   bit  quiet_tail;
   bit  req_taken;
   int  send_gap;
   int  take_gap;
   int  hold_off;
   bit  hold_off_armed;

   address_range_registry dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_base_address(req_base_address),
      .req_range_length(req_range_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_identity_hash(rsp_identity_hash), .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void place_range(logic [63:0] s, logic [63:0] e, logic [63:0] id);
      for (int i = 0; i < arr_pkg::TableEntries; i++) begin
         if (!model_valid[i]) begin
            model_valid[i] = 1'b1;
            model_start[i] = s;
            model_end[i] = e;
            model_ident[i] = id;
            model_count++;
            return;
         end
      end
   endfunction

   function automatic void carve_span(logic [63:0] lo, logic [63:0] hi);
      logic [63:0] s, e, id;
      for (int i = 0; i < arr_pkg::TableEntries; i++) begin
         if (model_valid[i]) begin
            s = model_start[i];
            e = model_end[i];
            id = model_ident[i];
            if (!(s >= hi || e <= lo)) begin
               model_valid[i] = 1'b0;
               model_count--;
               if (s < lo) place_range(s, lo, id);
               if (e > hi) place_range(hi, e, id);
            end
         end
      end
   endfunction

   function automatic logic [63:0] coverage_hash(logic [63:0] pos, logic [63:0] hi);
      logic [63:0] h;
      int hops;
      int found;
      h = arr_pkg::HashSeed;
      hops = 0;
      while (pos < hi) begin
         found = -1;
         for (int i = 0; i < arr_pkg::TableEntries; i++) begin
            if (found < 0 && model_valid[i] && model_start[i] <= pos && model_end[i] > pos)
               found = i;
         end
         if (found < 0 || hops > arr_pkg::TableEntries) return 64'd0;
         h = (h ^ model_ident[found]) * HashPrime;
         pos = model_end[found];
         hops++;
      end
      return (h == 64'd0) ? 64'd1 : h;
   endfunction

   function automatic answer_type predict_registry(range_word_type w);
      answer_type a;
      a.ident_hash = 64'd0;
      a.status = arr_pkg::ST_DONE;
      if (w.command != CmdUnused) begin
         if (w.base == 64'd0 || w.length == 64'd0 || w.length > ~w.base) begin
            a.status = arr_pkg::ST_INVALID;
         end else if (w.command == arr_pkg::CMD_QUERY) begin
            a.ident_hash = coverage_hash(w.base, w.base + w.length);
         end else if (model_count + 2 > arr_pkg::TableEntries) begin
            a.status = arr_pkg::ST_FULL;
         end else begin
            carve_span(w.base, w.base + w.length);
            if (w.command == arr_pkg::CMD_TRACK) begin
               model_counter++;
               place_range(w.base, w.base + w.length, model_counter);
            end
         end
      end
      return a;
   endfunction

   task automatic queue_word(logic [1:0] c, logic [63:0] b, logic [63:0] l);
      range_word_type w;
      w.command = c;
      w.base = b;
      w.length = l;
      pending_words.push_back(w);
   endtask

   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // Driver: inputs change on the falling edge, acceptance is judged on the rising edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_words.size() > 0) begin
         if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(1, 12);
         end else begin
            req_valid <= 1'b1;
            req_command <= pending_words[0].command;
            req_base_address <= pending_words[0].base;
            req_range_length <= pending_words[0].length;
            pending_words.pop_front();
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else if (hold_off_armed && words_sent >= 300) begin
         hold_off_armed <= 1'b0;
         rsp_ready <= 1'b0;
         hold_off <= 1500;
      end else if (take_gap > 0) begin
         rsp_ready <= 1'b0;
         take_gap <= take_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         take_gap <= $urandom_range(1, 12);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predicts on acceptance of a request word, checks each accepted response word.
   always @(posedge clock) begin
      answer_type a;
      range_word_type w;
      if (!reset) begin
         if (req_valid && req_ready) begin
            w.command = req_command;
            w.base = req_base_address;
            w.length = req_range_length;
            expected_answers.push_back(predict_registry(w));
            words_sent <= words_sent + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response word: hash %h status %0d",
                                              rsp_identity_hash, rsp_status);
            end else begin
               a = expected_answers.pop_front();
               if (a.ident_hash !== rsp_identity_hash || a.status !== rsp_status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected hash %h status %0d, got hash %h status %0d",
                              a.ident_hash, a.status, rsp_identity_hash, rsp_status);
               end
            end
         end
      end
   end

   function automatic logic [63:0] pick_address(int pool);
      logic [63:0] r;
      case ($urandom_range(0, 5))
         0: r = {$urandom, $urandom};
         1: r = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 4000);
         default: r = 64'h1000 + 64'(($urandom_range(0, pool)) * 16);
      endcase
      return r;
   endfunction

   function automatic logic [63:0] pick_length();
      logic [63:0] r;
      case ($urandom_range(0, 7))
         0: r = {$urandom, $urandom};
         1: r = 64'd0;
         default: r = 64'(($urandom_range(1, 40)) * 16);
      endcase
      return r;
   endfunction

   initial begin
      logic [63:0] b;
      logic [1:0] c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = arr_pkg::CMD_TRACK;
      req_base_address = 64'd0;
      req_range_length = 64'd0;
      rsp_ready = 1'b0;
      mismatches = 0;
      words_sent = 0;
      quiet_tail = 1'b0;
      req_taken = 1'b0;
      send_gap = 0;
      take_gap = 0;
      hold_off = 0;
      hold_off_armed = 1'b1;
      model_count = 0;
      model_counter = 64'd0;
      foreach (model_valid[i]) model_valid[i] = 1'b0;

      queue_word(arr_pkg::CMD_TRACK, 64'd0, 64'd16);
      queue_word(arr_pkg::CMD_TRACK, 64'h100, 64'd0);
      queue_word(arr_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFF0, 64'd32);
      queue_word(arr_pkg::CMD_FORGET, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_word(arr_pkg::CMD_TRACK, 64'hFFFF_FFFF_FFFF_FFF0, 64'd15);
      queue_word(arr_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFF0, 64'd15);
      queue_word(arr_pkg::CMD_TRACK, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(arr_pkg::CMD_TRACK, 64'h1000, 64'h100);
      queue_word(arr_pkg::CMD_TRACK, 64'h1040, 64'h40);
      queue_word(arr_pkg::CMD_QUERY, 64'h1000, 64'h100);
      queue_word(arr_pkg::CMD_FORGET, 64'h1080, 64'h10);
      queue_word(arr_pkg::CMD_QUERY, 64'h1000, 64'h100);
      queue_word(arr_pkg::CMD_QUERY, 64'h1000, 64'h80);
      queue_word(CmdUnused, 64'h1000, 64'h80);
      queue_word(arr_pkg::CMD_QUERY, 64'h5000_0000, 64'h10);
      queue_word(arr_pkg::CMD_FORGET, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE);
      queue_word(arr_pkg::CMD_QUERY, 64'h1000, 64'h10);
      // Many small disjoint ranges fill the table until tracking is refused.
      for (int i = 0; i < 66; i++)
         queue_word(arr_pkg::CMD_TRACK, 64'h10_0000 + i * 64'h100, 64'h10);
      queue_word(arr_pkg::CMD_FORGET, 64'h10_0000, 64'h20);
      queue_word(arr_pkg::CMD_QUERY, 64'h10_0000, 64'h10);
      queue_word(arr_pkg::CMD_FORGET, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 570; i++) begin
         c = ($urandom_range(0, 19) == 0) ? CmdUnused : 2'($urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0 && c != CmdUnused) c = arr_pkg::CMD_QUERY;
         b = pick_address((i % 100 < 50) ? 40 : 400);
         queue_word(c, b, pick_length());
         if (i == 450) quiet_tail = 1'b1;
         while (pending_words.size() > 8) @(posedge clock);
         if (i % 97 == 96) queue_word(arr_pkg::CMD_FORGET, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE);
      end
      while (pending_words.size() > 0 || req_valid) @(posedge clock);
      while (expected_answers.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
sv/arr_pkg.sv
sv/arr_store.sv
sv/address_range_registry.sv
dv/tb_address_range_registry.sv
